// ===== src/rcfcs_pkg.sv =====
package rcfcs_pkg;

  localparam int FRAME_LENGTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int RAW_W         = 16;
  localparam int SPAN_W        = 11;
  localparam int SUM_W         = 21;
  localparam int VAL_W         = 19;
  localparam int CH_COUNT      = 8;
  localparam int CH_AW         = 3;
  localparam int CH_FIRST_BYTE = 2;
  localparam int CH_LAST_BYTE  = CH_FIRST_BYTE + 2 * CH_COUNT - 1;

  localparam int STICK_W    = 16;
  localparam int THROTTLE_W = 19;
  localparam int SWITCH_W   = 9;
  localparam int OUT_DATA_W = 104;

  localparam int STICK_SPAN    = 200;
  localparam int THROTTLE_SPAN = 2000;
  localparam int SWITCH_SPAN   = 1;
  localparam int STICK_OFFSET  = 100;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_STICK_MIN    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_STICK_MAX    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_THROTTLE_MIN = 3'd2;
  localparam logic [CFG_AW-1:0] REG_THROTTLE_MAX = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SWITCH_MIN   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SWITCH_MAX   = 3'd5;

  localparam logic [RAW_W-1:0] STICK_MIN_RST    = 16'd4000;
  localparam logic [RAW_W-1:0] STICK_MAX_RST    = 16'd56000;
  localparam logic [RAW_W-1:0] THROTTLE_MIN_RST = 16'd4800;
  localparam logic [RAW_W-1:0] THROTTLE_MAX_RST = 16'd56000;
  localparam logic [RAW_W-1:0] SWITCH_MIN_RST   = 16'd55000;
  localparam logic [RAW_W-1:0] SWITCH_MAX_RST   = 16'd58000;

  typedef enum logic [1:0] {
    CLS_STICK,
    CLS_THROTTLE,
    CLS_SWITCH
  } ch_class_t;

  function automatic ch_class_t ch_class(input logic [CH_AW-1:0] ch);
    ch_class_t c;
    if (ch == 3'd2) begin
      c = CLS_THROTTLE;
    end else if (ch[2]) begin
      c = CLS_SWITCH;
    end else begin
      c = CLS_STICK;
    end
    return c;
  endfunction

endpackage

// ===== src/rcfcs_div.sv =====
module rcfcs_div #(
  parameter int DW  = 37,
  parameter int DVW = 17,
  parameter int QW  = 19
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [QW-1:0]  quotient
);

  localparam int CW = $clog2(DW + 1);

  logic           busy_r;
  logic           done_r;
  logic [CW-1:0]  cnt_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] div_r;
  logic [DW-1:0]  dvd_r;
  logic [QW-1:0]  quo_r;

  logic [DVW:0]   sh;
  logic [DVW:0]   diff;
  logic           ge;

  always_comb begin
    sh   = {rem_r, dvd_r[DW-1]};
    diff = sh - {1'b0, div_r};
    ge   = !diff[DVW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      dvd_r <= dividend;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVW-1:0] : sh[DVW-1:0];
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/rc_frame_channel_scaler.sv =====
// rc_frame_channel_scaler
// Receives RC receiver frames one byte per transfer on the in_ channel
// (in_tdata = byte, in_tuser = frame start flag). Channels one to eight are
// taken from bytes 2..17 as little-endian words and kept in an 8-entry
// channel memory. Bytes outside an open frame are dropped without a result.
// Ordinary bytes are taken at one per cycle while the sequencer is idle. The
// last byte of a frame starts the scaling sequencer: each channel is read
// from memory, clamped to its configured raw span, multiplied and divided by
// a shared restoring divider that retires one quotient bit per cycle.
// in_tready stays low from the frame end until the output register takes it.
// The result (eight scaled channels on out_tdata, the change flag on
// out_tuser) lands in an output register; the next frame's bytes are taken
// while it waits. If the receiver still holds the previous result when a new
// one is ready, the sequencer waits, and so does the input.
// Configuration registers are written through cfg_wr_en / cfg_addr /
// cfg_wdata while no frame end is being processed; the user must keep to
// this, since the block itself does not enforce it.
// Reset (rst_n low, synchronous) closes any open frame, clears the stored
// sum, drops a pending result and loads the default raw spans.
module rc_frame_channel_scaler #(
  parameter int FRAME_LENGTH  = rcfcs_pkg::FRAME_LENGTH_DEF,
  parameter int FRACTION_BITS = rcfcs_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // rx_byte
  input  logic [0:0]                        in_tuser,   // frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // stick_one_q8, stick_two_q8, throttle_q8, stick_four_q8,
  // switch_one_q8 .. switch_four_q8, zero pad
  output logic [rcfcs_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [0:0]                        out_tuser,  // changed
  input  logic                              cfg_wr_en,
  input  logic [rcfcs_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [rcfcs_pkg::RAW_W-1:0]       cfg_wdata
);

  localparam int PW     = $clog2(FRAME_LENGTH);
  localparam int RW     = rcfcs_pkg::RAW_W;
  localparam int SW     = rcfcs_pkg::SPAN_W;
  localparam int QW     = SW + FRACTION_BITS;
  localparam int PROD_W = RW + SW;
  localparam int DW     = PROD_W + FRACTION_BITS + 2;
  localparam int DVW    = RW + 1;
  localparam int SUMW   = rcfcs_pkg::SUM_W;
  localparam int VW     = rcfcs_pkg::VAL_W;
  localparam int STICK_BASE = rcfcs_pkg::STICK_OFFSET << FRACTION_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_GO   = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] pos_r;
  logic          in_frame_r;
  logic [7:0]    low_hold_r;

  logic [RW-1:0] stick_min_r, stick_max_r;
  logic [RW-1:0] thr_min_r, thr_max_r;
  logic [RW-1:0] sw_min_r, sw_max_r;

  logic [RW-1:0] mem [rcfcs_pkg::CH_COUNT];
  logic [RW-1:0] rd_data_r;

  logic [rcfcs_pkg::CH_AW-1:0] ch_r;
  logic [RW-1:0]     num_r, den_r;
  logic [SW-1:0]     span_r;
  logic              empty_r;
  logic [PROD_W-1:0] prod_r;
  logic [SUMW-1:0]   sum_r, last_sum_r;
  logic [VW-1:0]     val_r [rcfcs_pkg::CH_COUNT];

  logic                         out_tvalid_r;
  logic [rcfcs_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic                         out_changed_r;

  // byte intake
  logic          in_fire, start, active, is_ch, is_last;
  logic [PW-1:0] p, k;
  logic          mem_we;

  always_comb begin
    in_fire = in_tvalid && in_tready;
    start   = in_tuser[0];
    active  = start || in_frame_r;
    p       = start ? '0 : pos_r;
    k       = p - PW'(rcfcs_pkg::CH_FIRST_BYTE);
    is_ch   = (p >= PW'(rcfcs_pkg::CH_FIRST_BYTE)) && (p <= PW'(rcfcs_pkg::CH_LAST_BYTE));
    is_last = (p == PW'(FRAME_LENGTH - 1));
    mem_we  = in_fire && active && is_ch && k[0];
  end

  // channel prep
  rcfcs_pkg::ch_class_t cls;
  logic [RW-1:0] lo, hi, vc;
  logic [SW-1:0] span;

  always_comb begin
    cls = rcfcs_pkg::ch_class(ch_r);
    unique case (cls)
      rcfcs_pkg::CLS_THROTTLE: begin
        lo   = thr_min_r;
        hi   = thr_max_r;
        span = SW'(rcfcs_pkg::THROTTLE_SPAN);
      end
      rcfcs_pkg::CLS_SWITCH: begin
        lo   = sw_min_r;
        hi   = sw_max_r;
        span = SW'(rcfcs_pkg::SWITCH_SPAN);
      end
      default: begin
        lo   = stick_min_r;
        hi   = stick_max_r;
        span = SW'(rcfcs_pkg::STICK_SPAN);
      end
    endcase
    if (rd_data_r < lo) begin
      vc = lo;
    end else if (rd_data_r > hi) begin
      vc = hi;
    end else begin
      vc = rd_data_r;
    end
  end

  // divider
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend;
  logic [DVW-1:0] div_divisor;
  logic [QW-1:0] div_q;

  assign div_start    = (state_r == ST_GO);
  assign div_dividend = DW'({prod_r, {(FRACTION_BITS + 1){1'b0}}}) + DW'(den_r);
  assign div_divisor  = {den_r, 1'b0};

  rcfcs_div #(
    .DW  (DW),
    .DVW (DVW),
    .QW  (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [QW-1:0]   q_off;
  logic [SUMW-1:0] val;
  logic            fin_go;

  always_comb begin
    q_off = empty_r ? '0 : div_q;
    if (rcfcs_pkg::ch_class(ch_r) == rcfcs_pkg::CLS_STICK) begin
      val = SUMW'(q_off) - SUMW'(STICK_BASE);
    end else begin
      val = SUMW'(q_off);
    end
    fin_go = !out_tvalid_r || out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && active && is_last) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_GO;
      ST_GO:   state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (ch_r == '1) ? ST_FIN : ST_RD;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      in_frame_r   <= 1'b0;
      ch_r         <= '0;
      last_sum_r   <= '0;
      out_tvalid_r <= 1'b0;
      stick_min_r  <= rcfcs_pkg::STICK_MIN_RST;
      stick_max_r  <= rcfcs_pkg::STICK_MAX_RST;
      thr_min_r    <= rcfcs_pkg::THROTTLE_MIN_RST;
      thr_max_r    <= rcfcs_pkg::THROTTLE_MAX_RST;
      sw_min_r     <= rcfcs_pkg::SWITCH_MIN_RST;
      sw_max_r     <= rcfcs_pkg::SWITCH_MAX_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          rcfcs_pkg::REG_STICK_MIN:    stick_min_r <= cfg_wdata;
          rcfcs_pkg::REG_STICK_MAX:    stick_max_r <= cfg_wdata;
          rcfcs_pkg::REG_THROTTLE_MIN: thr_min_r   <= cfg_wdata;
          rcfcs_pkg::REG_THROTTLE_MAX: thr_max_r   <= cfg_wdata;
          rcfcs_pkg::REG_SWITCH_MIN:   sw_min_r    <= cfg_wdata;
          rcfcs_pkg::REG_SWITCH_MAX:   sw_max_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire && active) begin
        if (is_last) begin
          in_frame_r <= 1'b0;
          pos_r      <= '0;
          ch_r       <= '0;
        end else begin
          in_frame_r <= 1'b1;
          pos_r      <= p + 1'b1;
        end
      end
      if (state_r == ST_ACC) begin
        ch_r <= ch_r + 1'b1;
      end
      if (state_r == ST_FIN && fin_go) begin
        out_tvalid_r <= 1'b1;
        last_sum_r   <= sum_r;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // channel memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[k[rcfcs_pkg::CH_AW:1]] <= {in_tdata, low_hold_r};
    end
    rd_data_r <= mem[ch_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire && active && is_ch && !k[0]) begin
      low_hold_r <= in_tdata;
    end
    if (in_fire && active && is_last) begin
      sum_r <= '0;
    end
    if (state_r == ST_PREP) begin
      num_r   <= vc - lo;
      den_r   <= hi - lo;
      empty_r <= (hi <= lo);
      span_r  <= span;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(num_r) * PROD_W'(span_r);
    end
    if (state_r == ST_ACC) begin
      val_r[ch_r] <= val[VW-1:0];
      sum_r       <= sum_r + val;
    end
    if (state_r == ST_FIN && fin_go) begin
      out_tdata_r <= {
        1'b0,
        val_r[7][rcfcs_pkg::SWITCH_W-1:0],
        val_r[6][rcfcs_pkg::SWITCH_W-1:0],
        val_r[5][rcfcs_pkg::SWITCH_W-1:0],
        val_r[4][rcfcs_pkg::SWITCH_W-1:0],
        val_r[3][rcfcs_pkg::STICK_W-1:0],
        val_r[2][rcfcs_pkg::THROTTLE_W-1:0],
        val_r[1][rcfcs_pkg::STICK_W-1:0],
        val_r[0][rcfcs_pkg::STICK_W-1:0]
      };
      out_changed_r <= (sum_r != last_sum_r);
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_changed_r;

endmodule

// ===== src/rcfcs_chk.sv =====
module rcfcs_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rcfcs_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a new result only follows a busy cycle of the sequencer
  a_rose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without frame processing");

  // input closed while a result is taken: then no result, or the input was closed
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !in_tready |=> !out_tvalid || !$past(in_tready))
    else $error("unexpected result sequence");

endmodule

bind rc_frame_channel_scaler rcfcs_chk u_rcfcs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
